>>> hw/rtl/hce_pkg.sv
// Shared types and constants of the Huffman chunk encoder.
package hce_pkg;

    localparam int SYM_W  = 8;
    localparam int LEN_W  = 5;
    localparam int CODE_W = 24;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 2;

    typedef logic [OP_W-1:0] t_opcode;

    localparam t_opcode OP_LOAD   = 2'd0;
    localparam t_opcode OP_ENCODE = 2'd1;
    localparam t_opcode OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_tbl_entry;

endpackage

>>> hw/rtl/huffman_chunk_encoder_unit.sv
// Top level of the Huffman chunk encoder: table access, bit buffer and frame output.
// The block takes one transaction per cycle unless stalled. A load writes the code table at
// once; an encode reads the table when accepted and then updates the bit buffer, so encodes
// and loads follow back to back with no hazard. A frame is sent as one pad count byte and then
// ceil(fill/8) data bytes, one byte per cycle while i_ready is high; an encode that overflows
// the buffer or a flush that has bits pending waits while the emitter sends an earlier frame.
// The table needs no clearing pass after reset: each entry has a valid bit that reset clears.
module huffman_chunk_encoder_unit #(
    parameter int CHUNK_BITS  = 24,
    parameter int TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_symbol,
    input  logic [4:0]  i_code_length,
    input  logic [23:0] i_code_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_frame
);

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int FW      = $clog2(CHUNK_BITS + 1);
    localparam int SW      = FW + 1;
    localparam int LEN_LIM = (CHUNK_BITS < hce_pkg::CODE_W) ? CHUNK_BITS : hce_pkg::CODE_W;
    localparam logic [8:0] DEPTH_LIM = 9'(TABLE_DEPTH);

    logic                  accept;
    logic                  in_range;
    logic                  is_load;
    logic                  is_enc;
    logic                  is_flush;
    logic [4:0]            len_sat;
    logic [23:0]           code_mask;
    hce_pkg::t_tbl_entry   wr_entry;
    hce_pkg::t_tbl_entry   rd_entry;

    logic                  r_s1_vld;
    logic                  r_s1_flush;
    logic [CHUNK_BITS-1:0] r_buf;
    logic [FW-1:0]         r_fill;
    logic [CHUNK_BITS-1:0] n_buf;
    logic [FW-1:0]         n_fill;

    logic [SW-1:0]         sum;
    logic                  need_emit;
    logic                  s1_done;
    logic                  em_free;
    logic                  em_load;

    assign accept   = i_valid && o_ready;
    assign in_range = {1'b0, i_symbol} < DEPTH_LIM;
    assign is_load  = (i_opcode == hce_pkg::OP_LOAD);
    assign is_enc   = (i_opcode == hce_pkg::OP_ENCODE);
    assign is_flush = (i_opcode == hce_pkg::OP_FLUSH);

    always_comb begin
        len_sat       = (i_code_length > 5'(LEN_LIM)) ? 5'(LEN_LIM) : i_code_length;
        code_mask     = (24'd1 << len_sat) - 24'd1;
        wr_entry.len  = len_sat;
        wr_entry.code = i_code_bits & code_mask;
    end

    hce_code_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept && is_load && in_range),
        .i_waddr (i_symbol[AW-1:0]),
        .i_wdata (wr_entry),
        .i_re    (accept && is_enc && in_range),
        .i_raddr (i_symbol[AW-1:0]),
        .o_rdata (rd_entry)
    );

    always_comb begin
        sum    = SW'(r_fill) + SW'(rd_entry.len);
        n_buf  = r_buf;
        n_fill = r_fill;
        if (r_s1_flush) begin
            need_emit = (r_fill != '0);
            n_buf     = '0;
            n_fill    = '0;
        end else begin
            need_emit = (rd_entry.len != '0) && (sum > SW'(CHUNK_BITS));
            if (rd_entry.len != '0) begin
                if (need_emit) begin
                    n_buf  = CHUNK_BITS'(rd_entry.code);
                    n_fill = FW'(rd_entry.len);
                end else begin
                    n_buf  = (r_buf << rd_entry.len) | CHUNK_BITS'(rd_entry.code);
                    n_fill = FW'(sum);
                end
            end
        end
        s1_done = r_s1_vld && (!need_emit || em_free);
        em_load = r_s1_vld && need_emit && em_free;
    end

    assign o_ready = !r_s1_vld || s1_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s1_flush <= 1'b0;
            r_buf      <= '0;
            r_fill     <= '0;
        end else begin
            if (s1_done) begin
                r_buf  <= n_buf;
                r_fill <= n_fill;
            end
            if (accept) begin
                r_s1_vld   <= (is_enc && in_range) || is_flush;
                r_s1_flush <= is_flush;
            end else if (s1_done) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    hce_frame_emitter #(
        .CHUNK_BITS (CHUNK_BITS),
        .FW         (FW)
    ) u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (em_load),
        .i_bits  (r_buf),
        .i_fill  (r_fill),
        .o_free  (em_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_byte  (o_out_byte),
        .o_last  (o_last_of_frame)
    );

endmodule

>>> hw/rtl/hce_code_table.sv
// Code table memory with one valid bit per entry and a registered read port.
module hce_code_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  hce_pkg::t_tbl_entry i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output hce_pkg::t_tbl_entry o_rdata
);

    hce_pkg::t_tbl_entry mem [DEPTH];
    logic [DEPTH-1:0]    r_vld;
    hce_pkg::t_tbl_entry r_rdata;
    logic                r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

>>> hw/rtl/hce_frame_emitter.sv
// Frame emitter: sends the pad count byte and then the packed code bytes.
module hce_frame_emitter #(
    parameter int CHUNK_BITS = 24,
    parameter int FW         = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [CHUNK_BITS-1:0] i_bits,
    input  logic [FW-1:0]         i_fill,
    output logic                  o_free,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_byte,
    output logic                  o_last
);

    localparam int NBYTES_MAX = (CHUNK_BITS + hce_pkg::BYTE_W - 1) / hce_pkg::BYTE_W;
    localparam int FRM_W      = NBYTES_MAX * hce_pkg::BYTE_W;
    localparam int BCW        = $clog2(NBYTES_MAX + 1);
    localparam int SHW        = $clog2(FRM_W + 1);

    logic             r_ov;
    logic [7:0]       r_ob;
    logic             r_ol;
    logic             r_hdr;
    logic [BCW-1:0]   r_left;
    logic [FRM_W-1:0] r_sh;
    logic [2:0]       r_pad;

    logic             take;
    logic             active;
    logic             give;
    logic [FW:0]      nbytes_w;
    logic [BCW-1:0]   n_nbytes;
    logic [SHW-1:0]   n_shamt;
    logic [FRM_W-1:0] n_aligned;
    logic [2:0]       n_pad;

    assign take   = !r_ov || i_ready;
    assign active = r_hdr || (r_left != '0);
    assign give   = take && active;
    assign o_free = !active || (give && !r_hdr && (r_left == BCW'(1)));

    always_comb begin
        nbytes_w  = ((FW+1)'(i_fill) + (FW+1)'(hce_pkg::BYTE_W - 1)) >> 3;
        n_nbytes  = nbytes_w[BCW-1:0];
        n_shamt   = SHW'(FRM_W) - SHW'(i_fill);
        n_aligned = FRM_W'(i_bits) << n_shamt;
        n_pad     = 3'd0 - i_fill[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_hdr  <= 1'b0;
            r_left <= '0;
        end else begin
            if (give) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (give) begin
                if (r_hdr) begin
                    r_hdr <= 1'b0;
                end else begin
                    r_left <= r_left - BCW'(1);
                end
            end
            if (i_load) begin
                r_hdr  <= 1'b1;
                r_left <= n_nbytes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (give) begin
            if (r_hdr) begin
                r_ob <= {5'd0, r_pad};
                r_ol <= 1'b0;
            end else begin
                r_ob <= r_sh[FRM_W-1 -: 8];
                r_ol <= (r_left == BCW'(1));
                r_sh <= r_sh << 8;
            end
        end
        if (i_load) begin
            r_sh  <= n_aligned;
            r_pad <= n_pad;
        end
    end

    assign o_valid = r_ov;
    assign o_byte  = r_ob;
    assign o_last  = r_ol;

endmodule

>>> bench/huffman_chunk_encoder_unit_checker.sv
// Checker for the Huffman chunk encoder: predicts the output bytes and compares them.
module huffman_chunk_encoder_unit_checker #(
    parameter int CHUNK_BITS  = 24,
    parameter int TABLE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  hce_pkg::t_opcode              i_opcode,
    input  logic [hce_pkg::SYM_W-1:0]     i_symbol,
    input  logic [hce_pkg::LEN_W-1:0]     i_code_length,
    input  logic [hce_pkg::CODE_W-1:0]    i_code_bits,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [hce_pkg::BYTE_W-1:0]    i_out_byte,
    input  logic                          i_out_last,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_byte_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_LIMIT = (CHUNK_BITS < hce_pkg::CODE_W) ? CHUNK_BITS : hce_pkg::CODE_W;

    typedef struct packed {
        logic [hce_pkg::BYTE_W-1:0] value;
        logic                       is_last;
    } t_frame_byte;

    hce_pkg::t_tbl_entry code_table [TABLE_DEPTH];
    logic [63:0]         buffered_bits;
    int                  buffered_fill;
    t_frame_byte         expected_bytes [$];
    t_frame_byte         oldest;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic close_frame();
        int          nbytes;
        int          k;
        logic [63:0] aligned;
        t_frame_byte fb;
        if (buffered_fill != 0) begin
            nbytes = (buffered_fill + hce_pkg::BYTE_W - 1) / hce_pkg::BYTE_W;
            fb.value = hce_pkg::BYTE_W'((hce_pkg::BYTE_W - buffered_fill % hce_pkg::BYTE_W)
                                        % hce_pkg::BYTE_W);
            fb.is_last = 1'b0;
            expected_bytes.push_back(fb);
            aligned = buffered_bits << (64 - buffered_fill);
            for (k = 0; k < nbytes; k++) begin
                fb.value = aligned[63 - hce_pkg::BYTE_W * k -: hce_pkg::BYTE_W];
                fb.is_last = (k == nbytes - 1);
                expected_bytes.push_back(fb);
            end
            buffered_bits = '0;
            buffered_fill = 0;
        end
    endtask

    task automatic advance_encoder(input hce_pkg::t_opcode op,
                                   input logic [hce_pkg::SYM_W-1:0] sym,
                                   input logic [hce_pkg::LEN_W-1:0] len,
                                   input logic [hce_pkg::CODE_W-1:0] bits);
        int                  eff_len;
        hce_pkg::t_tbl_entry entry;
        case (op)
            hce_pkg::OP_LOAD: begin
                if (sym < TABLE_DEPTH) begin
                    eff_len = (len > LEN_LIMIT) ? LEN_LIMIT : len;
                    entry.len = hce_pkg::LEN_W'(eff_len);
                    entry.code = bits & hce_pkg::CODE_W'((64'd1 << eff_len) - 64'd1);
                    code_table[sym] = entry;
                end
            end
            hce_pkg::OP_ENCODE: begin
                if (sym < TABLE_DEPTH) begin
                    entry = code_table[sym];
                    if (entry.len != 0) begin
                        if (buffered_fill + entry.len > CHUNK_BITS) begin
                            close_frame();
                        end
                        buffered_bits = (buffered_bits << entry.len) | 64'(entry.code);
                        buffered_fill += entry.len;
                    end
                end
            end
            hce_pkg::OP_FLUSH: begin
                close_frame();
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (code_table[i]) code_table[i] = '0;
            buffered_bits = '0;
            buffered_fill = 0;
            expected_bytes.delete();
            o_fail_count = 0;
            o_byte_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("byte %02h arrived with nothing expected",
                                              i_out_byte));
                end else begin
                    oldest = expected_bytes.pop_front();
                    if (i_out_byte !== oldest.value) begin
                        report_mismatch($sformatf("byte %0d: value %02h, expected %02h",
                                                  o_byte_count, i_out_byte, oldest.value));
                    end
                    if (i_out_last !== oldest.is_last) begin
                        report_mismatch($sformatf("byte %0d: end-of-frame flag %b, expected %b",
                                                  o_byte_count, i_out_last, oldest.is_last));
                    end
                end
                o_byte_count++;
            end
            if (i_in_valid && i_in_ready) begin
                advance_encoder(i_opcode, i_symbol, i_code_length, i_code_bits);
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

>>> bench/huffman_chunk_encoder_unit_tb.sv
// Testbench top for the Huffman chunk encoder: clock, reset, stimulus and verdict.
module huffman_chunk_encoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int               CLK_PERIOD   = 4;
    localparam int               CHUNK_BITS   = 24;
    localparam int               TABLE_DEPTH  = 256;
    localparam int               RANDOM_ITEMS = 288;
    localparam int               HOLD_CYCLES  = 80;
    localparam hce_pkg::t_opcode OP_UNUSED    = 2'd3;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    hce_pkg::t_opcode i_opcode;
    logic [7:0]       i_symbol;
    logic [4:0]       i_code_length;
    logic [23:0]      i_code_bits;
    logic             o_valid;
    logic             i_ready;
    logic [7:0]       o_out_byte;
    logic             o_last_of_frame;

    int fail_count;
    int bytes_in_flight;
    int bytes_checked;
    int n_load;
    int n_encode;
    int n_flush;
    int n_unused;
    bit steady;
    bit hold_request;

    huffman_chunk_encoder_unit #(
        .CHUNK_BITS  (CHUNK_BITS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_symbol        (i_symbol),
        .i_code_length   (i_code_length),
        .i_code_bits     (i_code_bits),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_last_of_frame (o_last_of_frame)
    );

    huffman_chunk_encoder_unit_checker #(
        .CHUNK_BITS  (CHUNK_BITS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_opcode      (i_opcode),
        .i_symbol      (i_symbol),
        .i_code_length (i_code_length),
        .i_code_bits   (i_code_bits),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_byte    (o_out_byte),
        .i_out_last    (o_last_of_frame),
        .o_fail_count  (fail_count),
        .o_pending     (bytes_in_flight),
        .o_byte_count  (bytes_checked)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("huffman_chunk_encoder_unit: mismatch");
        $finish;
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                i_ready = 1'b0;
            end else if (hold_request) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (steady) begin
                i_ready = 1'b1;
            end else begin
                i_ready = ($urandom_range(0, 99) >= 19);
            end
        end
    end

    task automatic send_item(input hce_pkg::t_opcode op, input logic [7:0] sym,
                             input logic [4:0] len, input logic [23:0] bits);
        int gap;
        if (!steady && $urandom_range(0, 99) < 19) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_opcode = op;
        i_symbol = sym;
        i_code_length = len;
        i_code_bits = bits;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        case (op)
            hce_pkg::OP_LOAD:   n_load++;
            hce_pkg::OP_ENCODE: n_encode++;
            hce_pkg::OP_FLUSH:  n_flush++;
            default:            n_unused++;
        endcase
    endtask

    task automatic drain_to_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (bytes_in_flight != 0) @(negedge i_clk);
    endtask

    initial begin
        int               r;
        int               n;
        int               s;
        hce_pkg::t_opcode op;
        logic [7:0]       sym;
        logic [4:0]       len;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = hce_pkg::OP_LOAD;
        i_symbol = '0;
        i_code_length = '0;
        i_code_bits = '0;
        steady = 1'b0;
        hold_request = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(hce_pkg::OP_FLUSH, 8'h00, 5'd0, 24'h000000);
        send_item(OP_UNUSED, 8'h55, 5'd7, 24'hABCDEF);
        send_item(hce_pkg::OP_ENCODE, 8'h07, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_LOAD, 8'hFF, 5'd31, 24'hFFFFFF);
        send_item(hce_pkg::OP_LOAD, 8'h00, 5'd24, 24'h000000);
        send_item(hce_pkg::OP_LOAD, 8'h01, 5'd1, 24'hFFFFFF);
        send_item(hce_pkg::OP_LOAD, 8'h02, 5'd3, 24'hAAAAA5);
        send_item(hce_pkg::OP_LOAD, 8'h03, 5'd0, 24'hFFFFFF);
        send_item(hce_pkg::OP_ENCODE, 8'h01, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_ENCODE, 8'h02, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_FLUSH, 8'h00, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_ENCODE, 8'hFF, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_ENCODE, 8'h01, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_ENCODE, 8'h03, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_ENCODE, 8'h00, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_FLUSH, 8'h00, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_FLUSH, 8'h00, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_LOAD, 8'h02, 5'd8, 24'h5A5AA5);
        send_item(hce_pkg::OP_ENCODE, 8'h02, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_ENCODE, 8'h02, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_ENCODE, 8'h02, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_FLUSH, 8'h00, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_LOAD, 8'hFE, 5'd16, 24'hC31234);
        send_item(hce_pkg::OP_ENCODE, 8'hFE, 5'd0, 24'h000000);
        send_item(hce_pkg::OP_ENCODE, 8'hFE, 5'd0, 24'h000000);
        drain_to_idle();

        for (s = 0; s < 32; s++) begin
            send_item(hce_pkg::OP_LOAD, s[7:0], 5'($urandom_range(1, 12)), 24'($urandom));
        end
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 80) hold_request = 1'b1;
            if (n == 170) drain_to_idle();
            steady = (n >= 220 && n < 270);
            r = $urandom_range(0, 99);
            if (r < 12) begin
                op = hce_pkg::OP_LOAD;
            end else if (r < 82) begin
                op = hce_pkg::OP_ENCODE;
            end else if (r < 96) begin
                op = hce_pkg::OP_FLUSH;
            end else begin
                op = OP_UNUSED;
            end
            if ($urandom_range(0, 99) < 80) begin
                sym = 8'($urandom_range(0, 31));
            end else begin
                sym = 8'($urandom_range(0, 255));
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                len = 5'd0;
            end else if (r < 70) begin
                len = 5'($urandom_range(1, 10));
            end else if (r < 90) begin
                len = 5'($urandom_range(11, 24));
            end else begin
                len = 5'($urandom_range(25, 31));
            end
            send_item(op, sym, len, 24'($urandom));
        end
        drain_to_idle();
        repeat (20) @(negedge i_clk);

        $display("Run covered %0d loads, %0d encodes, %0d flushes, %0d unused opcodes;",
                 n_load, n_encode, n_flush, n_unused);
        $display("%0d output bytes compared across an output hold-off and a full drain.",
                 bytes_checked);
        if (fail_count == 0) begin
            $display("huffman_chunk_encoder_unit: match");
        end else begin
            $display("huffman_chunk_encoder_unit: mismatch");
        end
        $finish;
    end

endmodule

>>> huffman_chunk_encoder_unit.f
hw/rtl/hce_pkg.sv
hw/rtl/hce_code_table.sv
hw/rtl/hce_frame_emitter.sv
hw/rtl/huffman_chunk_encoder_unit.sv
bench/huffman_chunk_encoder_unit_checker.sv
bench/huffman_chunk_encoder_unit_tb.sv
